/* rtl/core/pvvc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvvc_pkg
// Shared types and constants of the PI velocity valve controller.
// ----------------------------------------------------------------------------
package pvvc_pkg;

  localparam int unsigned FULL_COURSE  = 1000;
  localparam int unsigned NARROW_RANGE = 1000;

  // Configuration register indexes.
  localparam logic [2:0] REG_SAMPLE_INTERVAL  = 3'd0;
  localparam logic [2:0] REG_DEAD_ZONE        = 3'd1;
  localparam logic [2:0] REG_COLD_GUESS_DROP  = 3'd2;
  localparam logic [2:0] REG_INTEGRATION_TIME = 3'd3;
  localparam logic [2:0] REG_GAIN_NUMERATOR   = 3'd4;
  localparam logic [2:0] REG_COURSE_DEADBAND  = 3'd5;

  // Result status codes.
  localparam logic [1:0] ST_WAITING   = 2'd0;
  localparam logic [1:0] ST_EVALUATED = 2'd1;
  localparam logic [1:0] ST_IDLE_BAND = 2'd2;
  localparam logic [1:0] ST_FAULT     = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV_KP,
    S_MUL_ERR,
    S_DIV_TI,
    S_MUL_DT,
    S_MUL_P,
    S_SUM,
    S_SCALE,
    S_FINISH,
    S_OUT
  } state_t;

  // Control group between the sequencer and the serial divider and multiplier.
  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [63:0] s;
    begin
      s = a + b;
      if (!a[63] && !b[63] && s[63]) begin
        sat_add = 64'sh7FFF_FFFF_FFFF_FFFF;
      end else if (a[63] && b[63] && !s[63]) begin
        sat_add = 64'sh8000_0000_0000_0000;
      end else begin
        sat_add = s;
      end
    end
  endfunction

endpackage

/* rtl/core/pvvc_sdiv.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvvc_sdiv
// Bit-serial signed 64-bit divider, one quotient bit per cycle, quotient
// truncated toward zero.
// ----------------------------------------------------------------------------
module pvvc_sdiv (
  input  logic                clk,
  input  logic                rst,
  input  pvvc_pkg::div_ctrl_t ctrl,
  input  logic signed [63:0]  dividend,
  input  logic [63:0]         divisor,
  output pvvc_pkg::div_stat_t stat,
  output logic signed [63:0]  quotient
);

  logic [63:0] rem;
  logic [63:0] quo;
  logic [63:0] dvs;
  logic        neg;
  logic [6:0]  count;
  logic        busy;
  logic        done;
  logic [64:0] trial;

  assign trial = {rem, quo[63]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy  <= 1'b1;
        count <= 7'd64;
      end else if (busy) begin
        count <= count - 7'd1;
        if (count == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      rem <= '0;
      quo <= dividend[63] ? 64'(-dividend) : dividend;
      dvs <= divisor;
      neg <= dividend[63];
    end else if (busy) begin
      if (!trial[64]) begin
        rem <= trial[63:0];
        quo <= {quo[62:0], 1'b1};
      end else begin
        rem <= {rem[62:0], quo[63]};
        quo <= {quo[62:0], 1'b0};
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = neg ? -$signed(quo) : $signed(quo);

endmodule

/* rtl/core/pvvc_smul.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvvc_smul
// Bit-serial shift-add multiplier: 64-bit signed value times a 64-bit
// magnitude, product saturated to signed 64 bits.
// ----------------------------------------------------------------------------
module pvvc_smul (
  input  logic                clk,
  input  logic                rst,
  input  pvvc_pkg::div_ctrl_t ctrl,
  input  logic signed [63:0]  a,
  input  logic [63:0]         m,
  output pvvc_pkg::div_stat_t stat,
  output logic signed [63:0]  product
);

  logic [63:0] mag;
  logic [63:0] mult;
  logic [64:0] acc;
  logic        ovf;
  logic        neg;
  logic        busy;
  logic        done;
  logic [6:0]  count;
  logic [65:0] acc_sum;

  // Multiplier bits are taken most significant first: acc = 2*acc + bit*mag.
  assign acc_sum = {acc, 1'b0} + (mult[63] ? {2'b00, mag} : 66'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy  <= 1'b1;
        count <= 7'd64;
      end else if (busy) begin
        count <= count - 7'd1;
        if (count == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      mag  <= a[63] ? 64'(-a) : a;
      mult <= m;
      acc  <= '0;
      ovf  <= 1'b0;
      neg  <= a[63];
    end else if (busy) begin
      mult <= {mult[62:0], 1'b0};
      if (acc_sum[65:63] != 3'd0) begin
        ovf <= 1'b1;
      end
      acc <= {2'b00, acc_sum[62:0]};
    end
  end

  // Magnitudes up to 2^63 are exact for negative results.
  always_comb begin
    if (mag == 64'd0 || !(ovf || acc[63])) begin
      product = neg ? -$signed(acc[63:0]) : $signed(acc[63:0]);
    end else if (neg) begin
      product = 64'sh8000_0000_0000_0000;
    end else begin
      product = 64'sh7FFF_FFFF_FFFF_FFFF;
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

/* rtl/core/pi_velocity_valve_controller.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pi_velocity_valve_controller
// Velocity-form PI mixing valve controller with per-mille course requests.
// ----------------------------------------------------------------------------
// Each sample transfer yields exactly one result transfer. The block works on
// one sample at a time. Samples that end before the PI step (waiting, sensor
// fault, dead zone, saturation jacketing, narrow range, first evaluation)
// load the output register at their own transfer edge, so the result is
// offered in the very next cycle, and the next sample can transfer in the
// cycle after that result transfer. A full PI step runs through one
// bit-serial 64-bit divider and one bit-serial 64-bit multiplier in turn:
// the gain division, the error product, the integral-time division, the
// elapsed-time product and the proportional product, then the sum step,
// the final scaling division and the finish and output steps. The serial
// units, not the comparisons, set how long a PI step takes. A finished
// result sits in an output register, and config writes are only expected
// while idle.
// ----------------------------------------------------------------------------
module pi_velocity_valve_controller #(
  parameter int unsigned FRAC_SCALE = 2097152
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [31:0]        sample_time,
  input  logic signed [23:0] target_temp,
  input  logic signed [23:0] outlet_temp,
  input  logic               outlet_ok,
  input  logic signed [23:0] hot_temp,
  input  logic               hot_ok,
  input  logic signed [23:0] cold_temp,
  input  logic               cold_ok,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic               request_valid,
  output logic               request_dir,
  output logic [9:0]         request_course
);

  // Configuration registers.
  logic [31:0] sample_interval;
  logic [22:0] dead_zone;
  logic [22:0] cold_guess_drop;
  logic [31:0] integration_time;
  logic [30:0] gain_numerator;
  logic [9:0]  course_deadband;

  // Controller state.
  logic [31:0]        last_sample_time;
  logic signed [23:0] previous_outlet;
  logic signed [63:0] held_integral;
  logic               loop_primed;

  pvvc_pkg::state_t state, state_next;

  // Captured sample and working values.
  logic signed [23:0] tgt, tout;
  logic signed [25:0] hot_adj, cold_adj;
  logic [31:0]        dt;
  logic signed [63:0] kp, acc, iterm;
  logic signed [63:0] div_a, mul_a;
  logic [63:0]        div_b, mul_b;
  logic signed [63:0] div_q, mul_p;

  pvvc_pkg::div_ctrl_t div_ctrl, mul_ctrl;
  pvvc_pkg::div_stat_t div_stat, mul_stat;

  // Front-end decode of a fresh sample (captured once on transfer).
  logic               take;
  logic [31:0]        dt_in;
  logic signed [25:0] half, h0, c0, h1, c1;
  logic               in_dz;
  logic [1:0]         f_status;
  logic               f_valid, f_dir, f_pi;
  logic [9:0]         f_course;

  assign take = in_valid && !in_stall;
  assign in_stall = (state != pvvc_pkg::S_IDLE) || out_valid;
  assign dt_in = sample_time - last_sample_time;

  always_comb begin
    half = 26'($unsigned(dead_zone[22:1]));
    h0 = 26'(hot_temp);
    c0 = cold_ok ? 26'(cold_temp) : (26'(hot_temp) - 26'($unsigned(cold_guess_drop)));
    h1 = h0;
    c1 = c0;
    if (26'(outlet_temp) > h0) begin
      h1 = 26'(outlet_temp);
    end else if (26'(outlet_temp) < c0) begin
      c1 = 26'(outlet_temp);
    end
    in_dz = ((26'(outlet_temp) - half) < 26'(target_temp)) &&
            (26'(target_temp) < (26'(outlet_temp) + half));
    f_status = pvvc_pkg::ST_EVALUATED;
    f_valid  = 1'b0;
    f_dir    = 1'b0;
    f_course = '0;
    f_pi     = 1'b0;
    if (dt_in < sample_interval) begin
      f_status = pvvc_pkg::ST_WAITING;
    end else if (!outlet_ok) begin
      f_status = pvvc_pkg::ST_FAULT;
    end else if (in_dz) begin
      f_status = pvvc_pkg::ST_IDLE_BAND;
    end else if (!hot_ok) begin
      f_status = pvvc_pkg::ST_FAULT;
    end else if (26'(target_temp) <= c1) begin
      f_valid = 1'b1; f_dir = 1'b1; f_course = 10'(pvvc_pkg::FULL_COURSE);
    end else if (26'(target_temp) >= h1) begin
      f_valid = 1'b1; f_course = 10'(pvvc_pkg::FULL_COURSE);
    end else if ((h1 - c1) <= 26'(pvvc_pkg::NARROW_RANGE)) begin
      f_status = pvvc_pkg::ST_IDLE_BAND;
    end else if (loop_primed) begin
      f_pi = 1'b1;
    end
  end

  // PI arithmetic values between steps.
  logic signed [63:0] pdiff;
  logic signed [63:0] sum_v;
  logic [63:0]        perth_mag;
  logic [9:0]         course_v;

  assign pdiff = 64'(previous_outlet) - 64'(tout);
  assign sum_v = pvvc_pkg::sat_add(pvvc_pkg::sat_add(iterm, acc), held_integral);
  assign perth_mag = div_q[63] ? 64'(-div_q) : div_q;
  assign course_v = (perth_mag > 64'(pvvc_pkg::FULL_COURSE)) ?
                    10'(pvvc_pkg::FULL_COURSE) : perth_mag[9:0];

  pvvc_sdiv u_div (
    .clk(clk), .rst(rst), .ctrl(div_ctrl), .dividend(div_a), .divisor(div_b),
    .stat(div_stat), .quotient(div_q)
  );

  pvvc_smul u_mul (
    .clk(clk), .rst(rst), .ctrl(mul_ctrl), .a(mul_a), .m(mul_b),
    .stat(mul_stat), .product(mul_p)
  );

  // Sequencer: next state and unit start pulses.
  always_comb begin
    state_next = state;
    div_ctrl.start = 1'b0;
    mul_ctrl.start = 1'b0;
    div_a = 64'(gain_numerator) * 64'd1000;
    div_b = 64'(hot_adj - cold_adj);
    mul_a = kp;
    mul_b = 64'(dt);
    case (state)
      pvvc_pkg::S_IDLE: begin
        if (take && f_pi) begin
          state_next = pvvc_pkg::S_DIV_KP;
        end
      end
      pvvc_pkg::S_DIV_KP: begin
        div_ctrl.start = !div_stat.busy && !div_stat.done && (acc == 64'sd0);
        if (div_stat.done) begin
          state_next = pvvc_pkg::S_MUL_ERR;
        end
      end
      pvvc_pkg::S_MUL_ERR: begin
        // The error carries the sign; the gain is never negative.
        mul_a = 64'(tgt) - 64'(tout);
        mul_b = $unsigned(kp);
        mul_ctrl.start = !mul_stat.busy && !mul_stat.done && (acc == 64'sd1);
        if (mul_stat.done) begin
          state_next = pvvc_pkg::S_DIV_TI;
        end
      end
      pvvc_pkg::S_DIV_TI: begin
        div_a = acc;
        div_b = (integration_time == 32'd0) ? 64'd1 : 64'(integration_time);
        div_ctrl.start = !div_stat.busy && !div_stat.done && (iterm == 64'sd0);
        if (div_stat.done) begin
          state_next = pvvc_pkg::S_MUL_DT;
        end
      end
      pvvc_pkg::S_MUL_DT: begin
        mul_a = acc;
        mul_b = 64'(dt);
        mul_ctrl.start = !mul_stat.busy && !mul_stat.done && (iterm == 64'sd1);
        if (mul_stat.done) begin
          state_next = pvvc_pkg::S_MUL_P;
        end
      end
      pvvc_pkg::S_MUL_P: begin
        mul_a = kp;
        mul_b = pdiff[63] ? 64'(-pdiff) : 64'(pdiff);
        mul_ctrl.start = !mul_stat.busy && !mul_stat.done && (acc == 64'sd1);
        if (mul_stat.done) begin
          state_next = pvvc_pkg::S_SUM;
        end
      end
      pvvc_pkg::S_SUM: begin
        state_next = pvvc_pkg::S_SCALE;
      end
      pvvc_pkg::S_SCALE: begin
        div_a = acc;
        div_b = 64'(FRAC_SCALE);
        div_ctrl.start = !div_stat.busy && !div_stat.done && (kp == 64'sd0);
        if (div_stat.done) begin
          state_next = pvvc_pkg::S_FINISH;
        end
      end
      pvvc_pkg::S_FINISH: begin
        state_next = pvvc_pkg::S_OUT;
      end
      pvvc_pkg::S_OUT: begin
        state_next = pvvc_pkg::S_IDLE;
      end
      default: begin
        state_next = pvvc_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pvvc_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Working registers. The acc/iterm/kp marks gate one start per phase.
  always_ff @(posedge clk) begin
    case (state)
      pvvc_pkg::S_IDLE: begin
        if (take) begin
          tgt      <= target_temp;
          tout     <= outlet_temp;
          hot_adj  <= h1;
          cold_adj <= c1;
          dt       <= dt_in;
          acc      <= 64'sd0;
          iterm    <= 64'sd0;
        end
      end
      pvvc_pkg::S_DIV_KP: begin
        if (div_stat.done) begin
          kp  <= div_q;
          acc <= 64'sd1;
        end
      end
      pvvc_pkg::S_MUL_ERR: begin
        // kp < 2^31 and |err| < 2^25, so the raw product fits.
        if (mul_stat.done) begin
          acc   <= mul_p;
          iterm <= 64'sd0;
        end
      end
      pvvc_pkg::S_DIV_TI: begin
        if (div_stat.done) begin
          acc   <= div_q;
          iterm <= 64'sd1;
        end
      end
      pvvc_pkg::S_MUL_DT: begin
        if (mul_stat.done) begin
          iterm <= mul_p;
          acc   <= 64'sd1;
        end
      end
      pvvc_pkg::S_MUL_P: begin
        if (mul_stat.done) begin
          acc <= pdiff[63] ? -mul_p : mul_p;
        end
      end
      pvvc_pkg::S_SUM: begin
        acc <= sum_v;
        kp  <= 64'sd0;
      end
      default: begin
      end
    endcase
  end

  // Controller state, output register and configuration.
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_interval  <= 32'd1;
      dead_zone        <= '0;
      cold_guess_drop  <= 23'd1000;
      integration_time <= 32'd1;
      gain_numerator   <= '0;
      course_deadband  <= '0;
      last_sample_time <= '0;
      previous_outlet  <= '0;
      held_integral    <= '0;
      loop_primed      <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          pvvc_pkg::REG_SAMPLE_INTERVAL:  sample_interval  <= cfg_data;
          pvvc_pkg::REG_DEAD_ZONE:        dead_zone        <= cfg_data[22:0];
          pvvc_pkg::REG_COLD_GUESS_DROP:  cold_guess_drop  <= cfg_data[22:0];
          pvvc_pkg::REG_INTEGRATION_TIME: integration_time <= cfg_data;
          pvvc_pkg::REG_GAIN_NUMERATOR:   gain_numerator   <= cfg_data[30:0];
          pvvc_pkg::REG_COURSE_DEADBAND:  course_deadband  <= cfg_data[9:0];
          default: begin
          end
        endcase
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (state == pvvc_pkg::S_IDLE && take) begin
        if (f_status != pvvc_pkg::ST_WAITING) begin
          last_sample_time <= sample_time;
        end
        if (!f_pi) begin
          out_valid      <= 1'b1;
          status         <= f_status;
          request_valid  <= f_valid;
          request_dir    <= f_dir;
          request_course <= f_course;
          // Dead zone, jacketing and narrow range unprime the loop; the
          // first full evaluation primes it.
          if (outlet_ok && (dt_in >= sample_interval)) begin
            if (in_dz || (hot_ok && (f_status == pvvc_pkg::ST_IDLE_BAND || f_valid))) begin
              loop_primed <= 1'b0;
            end else if (hot_ok && f_status == pvvc_pkg::ST_EVALUATED) begin
              loop_primed     <= 1'b1;
              previous_outlet <= outlet_temp;
              held_integral   <= '0;
            end
          end
        end
      end
      if (state == pvvc_pkg::S_OUT) begin
        out_valid     <= 1'b1;
        status        <= pvvc_pkg::ST_EVALUATED;
        request_dir   <= 1'b0;
        request_course <= '0;
        request_valid <= 1'b0;
        if (course_v < course_deadband) begin
          held_integral <= pvvc_pkg::sat_add(held_integral, iterm);
        end else begin
          previous_outlet <= tout;
          held_integral   <= '0;
          request_valid   <= 1'b1;
          // Direction follows the scaled value, so a sum that truncates to
          // zero opens.
          request_dir     <= div_q[63];
          request_course  <= course_v;
        end
      end
    end
  end

endmodule

/* rtl/core/pvvc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvvc_checker
// Port-level checks of the valve controller, bound to the top level.
// ----------------------------------------------------------------------------
module pvvc_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] status,
  input logic       request_valid,
  input logic       request_dir,
  input logic [9:0] request_course
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(request_course))
    else $error("stalled result changed");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("sample taken while a result waits");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second sample taken before the first finished");

  a_no_req_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && !request_valid |-> !request_dir && request_course == 10'd0)
    else $error("request fields set without a request");

  a_req_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && request_valid |-> status == pvvc_pkg::ST_EVALUATED &&
    request_course <= 10'd1000)
    else $error("request with wrong status or course");

endmodule

bind pi_velocity_valve_controller pvvc_checker u_pvvc_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .status(status),
  .request_valid(request_valid), .request_dir(request_dir),
  .request_course(request_course)
);
